/* hw/rtl/nbpc_pkg.sv */
// Package for the NCHW border pad and crop engine.
// Holds field widths, configuration register indexes, mode codes and defaults.
// No dependencies.
`default_nettype none

package nbpc_pkg;

	// Element and configuration port widths.
	localparam int ELEM_W      = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;

	// Configuration register field widths.
	localparam int PAD_W       = 4;
	localparam int SIDE_CFG_W  = 11;
	localparam int COUNT_CFG_W = 13;

	// Channel and image counters, and the largest count they serve.
	localparam int CNT_W       = 12;
	localparam int MAX_COUNT   = 4096;

	// Parameter defaults.
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_MAX_SIDE   = 1024;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_SIZE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_WORD      = 3'd6;

	// Operating modes.
	localparam logic MODE_PAD  = 1'b0;
	localparam logic MODE_CROP = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/nchw_border_pad_and_crop_core.sv */
// Top level of the NCHW border pad and crop engine.
// Depends on nbpc_pkg for widths, register indexes and mode codes.
//
// Usage: the source channel (src_valid / src_stall / offered_value) offers the
// next unconsumed source element on every transfer; the block walks one
// position of the padded grid (image, channel, row, column) per transfer and
// gives exactly one result transfer on the destination channel (dst_valid /
// dst_stall) with out_valid, out_value, took_input and tensor_done.
// In pad mode the border yields pad_word and leaves the offered element in
// place (took_input low); in crop mode every element is consumed and only
// inner elements are flagged with out_valid.
// A source transfer's result is registered and shows in the next cycle;
// throughput is one transfer per cycle when not stalled (one result register).
// When the receiver stalls, the result register holds and src_stall rises in
// the same cycle, so no source transfer is taken until the result leaves.
// Reset clears the grid counters and the result valid, and loads the registers
// with pad mode, border 1, all dimensions 1 and pad word 0.
// Configuration writes through cfg_we / cfg_index / cfg_data take effect at
// once; indexes past the pad word register are ignored.
`default_nettype none

module nchw_border_pad_and_crop_core #(
	parameter int DATA_WIDTH = nbpc_pkg::DEF_DATA_WIDTH,
	parameter int MAX_SIDE   = nbpc_pkg::DEF_MAX_SIDE
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port.
	input  wire logic                           cfg_we,
	input  wire logic [nbpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nbpc_pkg::CFG_W-1:0]     cfg_data,
	// Source channel.
	input  wire logic                           src_valid,
	output logic                                src_stall,
	input  wire logic [nbpc_pkg::ELEM_W-1:0]    offered_value,
	// Destination channel.
	output logic                                dst_valid,
	input  wire logic                           dst_stall,
	output logic                                out_valid,
	output logic [nbpc_pkg::ELEM_W-1:0]         out_value,
	output logic                                took_input,
	output logic                                tensor_done
);
	import nbpc_pkg::*;

	// Largest usable inner side: limited by the parameter and the register width.
	localparam int SIDE_REG_MAX = (1 << SIDE_CFG_W) - 1;
	localparam int SIDE_LIM_I   = (MAX_SIDE < SIDE_REG_MAX) ? MAX_SIDE : SIDE_REG_MAX;
	localparam int PAD_MAX      = (1 << PAD_W) - 1;
	// Row and column positions must hold the padded side.
	localparam int POS_W        = $clog2(SIDE_LIM_I + 2 * PAD_MAX + 1);
	localparam logic [SIDE_CFG_W-1:0]  SIDE_LIM  = SIDE_CFG_W'(SIDE_LIM_I);
	localparam logic [COUNT_CFG_W-1:0] COUNT_LIM = COUNT_CFG_W'(MAX_COUNT);
	// Element values keep at most DATA_WIDTH low bits.
	localparam int MASK_W = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;
	localparam logic [ELEM_W-1:0] DATA_MASK = {ELEM_W{1'b1}} >> (ELEM_W - MASK_W);

	// Configuration registers.
	logic                   mode_q;
	logic [PAD_W-1:0]       pad_size_q;
	logic [SIDE_CFG_W-1:0]  inner_height_q;
	logic [SIDE_CFG_W-1:0]  inner_width_q;
	logic [COUNT_CFG_W-1:0] channel_count_q;
	logic [COUNT_CFG_W-1:0] batch_count_q;
	logic [ELEM_W-1:0]      pad_word_q;

	// Grid position counters.
	logic [POS_W-1:0] col_pos_q;
	logic [POS_W-1:0] row_pos_q;
	logic [CNT_W-1:0] chan_pos_q;
	logic [CNT_W-1:0] image_pos_q;

	// Result register.
	logic              res_valid_s1;
	logic              out_valid_s1;
	logic [ELEM_W-1:0] out_value_s1;
	logic              took_input_s1;
	logic              tensor_done_s1;

	// Effective sizes and position decode.
	logic [SIDE_CFG_W-1:0]  h_eff;
	logic [SIDE_CFG_W-1:0]  w_eff;
	logic [COUNT_CFG_W-1:0] nc_eff;
	logic [COUNT_CFG_W-1:0] nb_eff;
	logic [POS_W-1:0]       p_ext;
	logic [POS_W-1:0]       h_ext;
	logic [POS_W-1:0]       w_ext;
	logic [POS_W-1:0]       row_end;
	logic [POS_W-1:0]       col_end;
	logic [POS_W-1:0]       row_last_pos;
	logic [POS_W-1:0]       col_last_pos;
	logic                   in_core;
	logic                   col_last;
	logic                   row_last;
	logic                   chan_last;
	logic                   image_last;
	logic                   src_xfer;
	logic                   dst_xfer;
	logic [ELEM_W-1:0]      offered_m;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_PAD;
			pad_size_q      <= PAD_W'(1);
			inner_height_q  <= SIDE_CFG_W'(1);
			inner_width_q   <= SIDE_CFG_W'(1);
			channel_count_q <= COUNT_CFG_W'(1);
			batch_count_q   <= COUNT_CFG_W'(1);
			pad_word_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:          mode_q          <= cfg_data[0];
				REG_PAD_SIZE:      pad_size_q      <= cfg_data[PAD_W-1:0];
				REG_INNER_HEIGHT:  inner_height_q  <= cfg_data[SIDE_CFG_W-1:0];
				REG_INNER_WIDTH:   inner_width_q   <= cfg_data[SIDE_CFG_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[COUNT_CFG_W-1:0];
				REG_BATCH_COUNT:   batch_count_q   <= cfg_data[COUNT_CFG_W-1:0];
				REG_PAD_WORD:      pad_word_q      <= cfg_data[ELEM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions: zero counts as one, oversized values saturate.
	always_comb begin
		if (inner_height_q == '0)
			h_eff = SIDE_CFG_W'(1);
		else if (inner_height_q > SIDE_LIM)
			h_eff = SIDE_LIM;
		else
			h_eff = inner_height_q;

		if (inner_width_q == '0)
			w_eff = SIDE_CFG_W'(1);
		else if (inner_width_q > SIDE_LIM)
			w_eff = SIDE_LIM;
		else
			w_eff = inner_width_q;

		if (channel_count_q == '0)
			nc_eff = COUNT_CFG_W'(1);
		else if (channel_count_q > COUNT_LIM)
			nc_eff = COUNT_LIM;
		else
			nc_eff = channel_count_q;

		if (batch_count_q == '0)
			nb_eff = COUNT_CFG_W'(1);
		else if (batch_count_q > COUNT_LIM)
			nb_eff = COUNT_LIM;
		else
			nb_eff = batch_count_q;
	end

	// Border decode and last-position flags for the current grid position.
	always_comb begin
		p_ext        = POS_W'(pad_size_q);
		h_ext        = POS_W'(h_eff);
		w_ext        = POS_W'(w_eff);
		row_end      = h_ext + p_ext;
		col_end      = w_ext + p_ext;
		row_last_pos = row_end + p_ext - POS_W'(1);
		col_last_pos = col_end + p_ext - POS_W'(1);
		in_core      = (row_pos_q >= p_ext) && (row_pos_q < row_end) &&
		               (col_pos_q >= p_ext) && (col_pos_q < col_end);
		col_last     = col_pos_q >= col_last_pos;
		row_last     = row_pos_q >= row_last_pos;
		chan_last    = {1'b0, chan_pos_q} >= (nc_eff - COUNT_CFG_W'(1));
		image_last   = {1'b0, image_pos_q} >= (nb_eff - COUNT_CFG_W'(1));
		offered_m    = offered_value & DATA_MASK;
	end

	// Handshakes: a new transfer is taken unless a held result is stalled.
	assign dst_xfer  = res_valid_s1 && !dst_stall;
	assign src_stall = res_valid_s1 && dst_stall;
	assign src_xfer  = src_valid && !src_stall;

	// Grid counters advance column first, carrying into row, channel and image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q   <= '0;
			row_pos_q   <= '0;
			chan_pos_q  <= '0;
			image_pos_q <= '0;
		end else if (src_xfer) begin
			if (!col_last) begin
				col_pos_q <= col_pos_q + POS_W'(1);
			end else begin
				col_pos_q <= '0;
				if (!row_last) begin
					row_pos_q <= row_pos_q + POS_W'(1);
				end else begin
					row_pos_q <= '0;
					if (!chan_last) begin
						chan_pos_q <= chan_pos_q + CNT_W'(1);
					end else begin
						chan_pos_q <= '0;
						if (!image_last)
							image_pos_q <= image_pos_q + CNT_W'(1);
						else
							image_pos_q <= '0;
					end
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (src_xfer) begin
			res_valid_s1 <= 1'b1;
		end else if (dst_xfer) begin
			res_valid_s1 <= 1'b0;
		end
	end

	// Result payload, loaded on every source transfer.
	always_ff @(posedge clk) begin
		if (src_xfer) begin
			tensor_done_s1 <= col_last && row_last && chan_last && image_last;
			if (mode_q == MODE_PAD) begin
				out_valid_s1  <= 1'b1;
				took_input_s1 <= in_core;
				out_value_s1  <= in_core ? offered_m : (pad_word_q & DATA_MASK);
			end else begin
				out_valid_s1  <= in_core;
				took_input_s1 <= 1'b1;
				out_value_s1  <= in_core ? offered_m : '0;
			end
		end
	end

	assign dst_valid   = res_valid_s1;
	assign out_valid   = out_valid_s1;
	assign out_value   = out_value_s1;
	assign took_input  = took_input_s1;
	assign tensor_done = tensor_done_s1;

endmodule

`default_nettype wire
